[src/sixel_glyph_row_decoder_core_macros.svh]
// Assertion helpers shared by the decoder modules.
// Each macro expands to one labeled concurrent assertion clocked on clk,
// disabled while rst is high.
`ifndef SIXEL_GLYPH_ROW_DECODER_CORE_MACROS_SVH
`define SIXEL_GLYPH_ROW_DECODER_CORE_MACROS_SVH

// Same-cycle implication.
`define SGRD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sgrd assertion failed");

// Next-cycle implication.
`define SGRD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sgrd assertion failed");

`endif

[src/sgrd_pkg.sv]
`default_nettype none

package sgrd_pkg;

  localparam int MAX_WIDTH  = 15;
  localparam int MAX_HEIGHT = 12;
  localparam int BAND_ROWS  = 6;

  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

  // byte codes
  localparam logic [7:0] CHAR_QMARK = 8'h3F;
  localparam logic [7:0] CHAR_TILDE = 8'h7E;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_SEMI  = 8'h3B;
  localparam logic [7:0] CHAR_BEL   = 8'h07;
  localparam logic [7:0] HIGH_LIMIT = 8'd128;

  localparam logic [6:0] GLYPH_LIMIT = 7'd96;
  localparam logic [4:0] LOWER_BASE  = 5'd16;

  localparam logic [3:0] RESET_WIDTH  = 4'd15;
  localparam logic [3:0] RESET_HEIGHT = 4'd12;
  localparam logic [6:0] RESET_START  = 7'd1;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_START  = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    CMD_FILL  = 1'b0,
    CMD_CLOSE = 1'b1
  } cmd_kind_t;

  // front to back request
  typedef struct packed {
    cmd_kind_t   kind;
    logic [4:0]  addr;   // column slot, bit 4 selects the lower band
    logic [5:0]  data;   // sixel bits, LSB on top
    logic [6:0]  gnum;
    logic        done;
    logic [6:0]  owed;
  } cmd_t;

  // clamped glyph geometry
  typedef struct packed {
    logic [3:0] width;
    logic [3:0] height;
  } geom_t;

  function automatic logic [3:0] eff_width(input logic [3:0] w);
    logic [3:0] r;
    r = w;
    if (r < 4'd5) r = 4'd5;
    if (r > 4'(MAX_WIDTH)) r = 4'(MAX_WIDTH);
    return r;
  endfunction

  function automatic logic [3:0] eff_height(input logic [3:0] h);
    logic [3:0] r;
    r = h;
    if (r == 4'd0) r = 4'd1;
    if (r > 4'(MAX_HEIGHT)) r = 4'(MAX_HEIGHT);
    return r;
  endfunction

  function automatic logic [6:0] glyph_total(input logic [6:0] s);
    logic [6:0] r;
    r = s;
    if (r == 7'd0) r = 7'd1;
    if (r > GLYPH_LIMIT - 7'd1) r = GLYPH_LIMIT - 7'd1;
    return GLYPH_LIMIT - r;
  endfunction

endpackage

`default_nettype wire

[src/sgrd_queue.sv]
`default_nettype none

module sgrd_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire sgrd_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output logic               full,
  output logic               empty,
  output sgrd_pkg::cmd_t     head
);

  `include "sixel_glyph_row_decoder_core_macros.svh"

  sgrd_pkg::cmd_t mem [sgrd_pkg::QUEUE_DEPTH];
  logic [sgrd_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [sgrd_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [sgrd_pkg::QUEUE_AW:0]   count;

  assign full  = (count == (sgrd_pkg::QUEUE_AW+1)'(sgrd_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `SGRD_ASSERT_NEXT(a_queue_grows, push && !pop, count == $past(count) + 1'b1)

endmodule

`default_nettype wire

[src/sgrd_front.sv]
`default_nettype none

module sgrd_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [7:0]    s_tdata,
  input  wire logic          s_tlast,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [6:0]    cfg_data,
  input  wire logic          q_full,
  output logic               q_push,
  output sgrd_pkg::cmd_t     q_cmd,
  output sgrd_pkg::geom_t    geom
);

  `include "sixel_glyph_row_decoder_core_macros.svh"

  logic [3:0] width_reg;
  logic [3:0] height_reg;
  logic [6:0] start_reg;
  logic [4:0] fill_index;
  logic [6:0] remaining;
  logic       finished;

  logic       accept;
  logic       halted;
  logic       is_stop;
  logic       is_close;
  logic       is_slash;
  logic       is_sixel;
  logic       room;
  logic [6:0] rem_dec;
  logic       done;
  logic [7:0] sixel_val;

  assign geom.width  = sgrd_pkg::eff_width(width_reg);
  assign geom.height = sgrd_pkg::eff_height(height_reg);

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign halted   = finished || (remaining == 7'd0);

  // classify
  assign is_stop  = s_tlast || (s_tdata == sgrd_pkg::CHAR_BEL) ||
                    (s_tdata > sgrd_pkg::HIGH_LIMIT);
  assign is_close = is_stop || (s_tdata == sgrd_pkg::CHAR_SEMI);
  assign is_slash = (s_tdata == sgrd_pkg::CHAR_SLASH);
  assign is_sixel = (s_tdata >= sgrd_pkg::CHAR_QMARK) && (s_tdata <= sgrd_pkg::CHAR_TILDE);
  assign room     = (fill_index[3:0] < geom.width);

  assign rem_dec   = remaining - 7'd1;
  assign done      = is_stop || (rem_dec == 7'd0);
  assign sixel_val = s_tdata - sgrd_pkg::CHAR_QMARK;

  assign q_push = accept && !halted && (is_close || (is_sixel && room));

  always_comb begin
    q_cmd.kind = is_close ? sgrd_pkg::CMD_CLOSE : sgrd_pkg::CMD_FILL;
    q_cmd.addr = fill_index;
    q_cmd.data = sixel_val[5:0];
    q_cmd.gnum = sgrd_pkg::glyph_total(start_reg) - remaining;
    q_cmd.done = done;
    q_cmd.owed = is_stop ? rem_dec : 7'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= sgrd_pkg::RESET_WIDTH;
      height_reg <= sgrd_pkg::RESET_HEIGHT;
      start_reg  <= sgrd_pkg::RESET_START;
      fill_index <= '0;
      remaining  <= sgrd_pkg::glyph_total(sgrd_pkg::RESET_START);
      finished   <= 1'b0;
    end else begin
      if (accept) begin
        if (halted) begin
          finished <= 1'b1;
        end else if (is_close) begin
          remaining  <= rem_dec;
          fill_index <= '0;
          if (done) finished <= 1'b1;
        end else if (is_slash) begin
          fill_index <= sgrd_pkg::LOWER_BASE;
        end else if (is_sixel && room) begin
          fill_index <= fill_index + 5'd1;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          sgrd_pkg::REG_WIDTH: begin
            width_reg <= cfg_data[3:0];
          end
          sgrd_pkg::REG_HEIGHT: begin
            height_reg <= cfg_data[3:0];
          end
          sgrd_pkg::REG_START: begin
            start_reg <= cfg_data;
            remaining <= sgrd_pkg::glyph_total(cfg_data);
          end
          default: begin
          end
        endcase
      end
    end
  end

  `SGRD_ASSERT_IMP(a_no_push_after_end, finished, !q_push)

endmodule

`default_nettype wire

[src/sgrd_back.sv]
`default_nettype none

module sgrd_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_empty,
  input  wire sgrd_pkg::cmd_t q_head,
  output logic               q_pop,
  input  wire sgrd_pkg::geom_t geom,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [39:0]        m_tdata,
  output logic               m_tlast,
  output logic               m_tuser
);

  `include "sixel_glyph_row_decoder_core_macros.svh"

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t     state;
  logic [3:0] row_idx;
  logic [6:0] gnum_q;
  logic       done_q;
  logic [6:0] owed_q;

  logic [5:0] upper [sgrd_pkg::MAX_WIDTH];
  logic [5:0] lower [sgrd_pkg::MAX_WIDTH];

  logic                          load;
  logic                          emit_row;
  logic                          last_now;
  logic                          in_lower;
  logic [2:0]                    bit_sel;
  logic [sgrd_pkg::MAX_WIDTH-1:0] row_bits;
  logic [3:0]                    row_m6;

  assign load     = !m_tvalid || m_tready;
  assign q_pop    = (state == ST_IDLE) && !q_empty;
  assign emit_row = (state == ST_EMIT) && load;
  assign last_now = (row_idx == geom.height - 4'd1);

  // rows 6 and up come from the lower band
  assign in_lower = (row_idx >= 4'(sgrd_pkg::BAND_ROWS));
  assign row_m6   = row_idx - 4'(sgrd_pkg::BAND_ROWS);
  assign bit_sel  = in_lower ? row_m6[2:0] : row_idx[2:0];

  always_comb begin
    for (int x = 0; x < sgrd_pkg::MAX_WIDTH; x++) begin
      row_bits[x] = (4'(x) < geom.width) &&
                    (in_lower ? lower[x][bit_sel] : upper[x][bit_sel]);
    end
  end

  // column store
  always_ff @(posedge clk) begin
    if (rst || emit_row && last_now) begin
      for (int x = 0; x < sgrd_pkg::MAX_WIDTH; x++) begin
        upper[x] <= '0;
        lower[x] <= '0;
      end
    end else if (q_pop && q_head.kind == sgrd_pkg::CMD_FILL) begin
      if (q_head.addr[4]) begin
        lower[q_head.addr[3:0]] <= q_head.data;
      end else begin
        upper[q_head.addr[3:0]] <= q_head.data;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      row_idx <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_pop && q_head.kind == sgrd_pkg::CMD_CLOSE) begin
            state   <= ST_EMIT;
            row_idx <= '0;
          end
        end
        ST_EMIT: begin
          if (emit_row) begin
            if (last_now) begin
              state <= ST_IDLE;
            end else begin
              row_idx <= row_idx + 4'd1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.kind == sgrd_pkg::CMD_CLOSE) begin
      gnum_q <= q_head.gnum;
      done_q <= q_head.done;
      owed_q <= q_head.owed;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_row) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_row) begin
      m_tdata <= {7'd0, (last_now && done_q) ? owed_q : 7'd0, gnum_q, row_idx, row_bits};
      m_tlast <= last_now;
      m_tuser <= last_now && done_q;
    end
  end

  `SGRD_ASSERT_NEXT(a_emit_ends, emit_row && last_now, state == ST_IDLE)
  `SGRD_ASSERT_IMP(a_done_on_last, m_tvalid && m_tuser, m_tlast)
  `SGRD_ASSERT_IMP(a_pop_only_idle, q_pop, state == ST_IDLE && !q_empty)

endmodule

`default_nettype wire

[src/sixel_glyph_row_decoder_core.sv]
// Sixel soft-font glyph row decoder.
// Input stream (s_*): one font-body byte per request in s_tdata[7:0];
// s_tlast marks end of stream (the byte is then ignored). Sixel bytes fill
// glyph columns, '/' moves to the lower band, ';', BEL, bytes above 128 or
// end of stream close the glyph. Output stream (m_*): one request per glyph
// row, m_tlast on the glyph's final row, m_tuser on the final row once
// decoding has ended, with the count of blank glyphs still owed in tdata.
// Throughput: one byte per cycle unless the request queue is full. A glyph
// close passes the four-entry request queue and the sequencer, then sends
// glyph_height rows through the single output register, popping nothing
// more until its last row is loaded. The queue lets the byte side run while
// rows drain. When m_tready is low the row holds, the queue fills and then
// s_tready drops. Reset (synchronous rst) loads width 15, height 12, start
// 1, empties the queue and clears the column store. Configuration writes
// (cfg_we, cfg_index, cfg_data) are taken at once, no read-back.
`default_nettype none

module sixel_glyph_row_decoder_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
  input  wire logic        s_tlast,   // end_of_stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [14:0] row_bits, [18:15] row_number,
                                      // [25:19] glyph_number,
                                      // [32:26] blank_glyphs_left, rest zero
  output logic             m_tlast,   // last_row
  output logic             m_tuser,   // [0] stream_done
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index, // 0 width, 1 height, 2 start_char
  input  wire logic [6:0]  cfg_data
);

  logic            q_full;
  logic            q_empty;
  logic            q_push;
  logic            q_pop;
  sgrd_pkg::cmd_t  q_cmd;
  sgrd_pkg::cmd_t  q_head;
  sgrd_pkg::geom_t geom;

  // byte classifier, config registers, glyph bookkeeping
  sgrd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd),
    .geom      (geom)
  );

  // fill / close requests in order
  sgrd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  // column store and row emitter
  sgrd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .geom     (geom),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

[tb/tb_sixel_glyph_row_decoder_core.sv]
module tb_sixel_glyph_row_decoder_core;
  timeunit 1ns;
  timeprecision 1ps;

  // Byte budget for the random part. Requests that the decoder simply skips
  // are not counted.
  localparam int ITEM_GOAL   = 500;
  // Past this point both sides run without idling.
  localparam int QUIET_AFTER = 430;

  // One emitted glyph row, as it appears on the master side.
  typedef struct packed {
    logic [6:0]  pad;    // m_tdata[39:33], always zero
    logic [6:0]  owed;   // blank_glyphs_left
    logic        done;   // stream_done (m_tuser)
    logic        last;   // last_row (m_tlast)
    logic [6:0]  glyph;  // glyph_number
    logic [3:0]  row;    // row_number
    logic [14:0] bits;   // row_bits
  } glyph_row_t;

  typedef enum logic {
    DIR_BYTE,
    DIR_CFG
  } dir_kind_t;

  // Directed step. For DIR_CFG the code field carries the register value.
  // pin_rows != 0 means the rows of the glyph closed here are typed in below
  // (all rows equal pin_bits, glyph pin_glyph, no stream end).
  typedef struct packed {
    dir_kind_t          kind;
    sgrd_pkg::cfg_reg_t sel;
    logic [7:0]         code;
    logic [3:0]         reps;
    logic [3:0]         pin_rows;
    logic [14:0]        pin_bits;
    logic [6:0]         pin_glyph;
  } dir_step_t;

  // How the font body ends in this run. The decoder stops for good on the
  // first of these, so only one can be taken per reset.
  typedef enum logic [1:0] {
    END_BEL,
    END_HIGH,
    END_EOS,
    END_LAST_GLYPH
  } font_end_t;

  localparam int DIR_LEN = 23;
  localparam dir_step_t DIR_TAB [DIR_LEN] = '{
    // blank glyph right after reset: 12 empty rows, glyph 0
    '{DIR_BYTE, sgrd_pkg::REG_WIDTH,  sgrd_pkg::CHAR_SEMI,  4'd1, 4'd12, 15'h0000, 7'd0},
    // narrowest glyph, height above the maximum
    '{DIR_CFG,  sgrd_pkg::REG_WIDTH,  8'd0,                 4'd1, 4'd0,  15'h0000, 7'd0},
    '{DIR_CFG,  sgrd_pkg::REG_HEIGHT, 8'd15,                4'd1, 4'd0,  15'h0000, 7'd0},
    // six full sixels into a five-column band: the sixth is dropped
    '{DIR_BYTE, sgrd_pkg::REG_WIDTH,  sgrd_pkg::CHAR_TILDE, 4'd6, 4'd0,  15'h0000, 7'd0},
    '{DIR_BYTE, sgrd_pkg::REG_WIDTH,  sgrd_pkg::CHAR_SLASH, 4'd1, 4'd0,  15'h0000, 7'd0},
    '{DIR_BYTE, sgrd_pkg::REG_WIDTH,  sgrd_pkg::CHAR_TILDE, 4'd5, 4'd0,  15'h0000, 7'd0},
    '{DIR_BYTE, sgrd_pkg::REG_WIDTH,  sgrd_pkg::CHAR_SEMI,  4'd1, 4'd12, 15'h001F, 7'd1},
    // skipped bytes: NUL, 128, ESC, just below '?', just above '~'
    '{DIR_BYTE, sgrd_pkg::REG_WIDTH,  8'h00,                4'd1, 4'd0,  15'h0000, 7'd0},
    '{DIR_BYTE, sgrd_pkg::REG_WIDTH,  sgrd_pkg::HIGH_LIMIT, 4'd1, 4'd0,  15'h0000, 7'd0},
    '{DIR_BYTE, sgrd_pkg::REG_WIDTH,  8'h1B,                4'd1, 4'd0,  15'h0000, 7'd0},
    '{DIR_BYTE, sgrd_pkg::REG_WIDTH,  sgrd_pkg::CHAR_QMARK - 8'd1,
      4'd1, 4'd0, 15'h0000, 7'd0},
    '{DIR_BYTE, sgrd_pkg::REG_WIDTH,  sgrd_pkg::CHAR_TILDE + 8'd1,
      4'd1, 4'd0, 15'h0000, 7'd0},
    // height 0 clamps to one row; start 0 clamps to 1 and restarts numbering
    '{DIR_CFG,  sgrd_pkg::REG_HEIGHT, 8'd0,                 4'd1, 4'd0,  15'h0000, 7'd0},
    '{DIR_CFG,  sgrd_pkg::REG_START,  8'd0,                 4'd1, 4'd0,  15'h0000, 7'd0},
    '{DIR_BYTE, sgrd_pkg::REG_WIDTH,  sgrd_pkg::CHAR_QMARK, 4'd1, 4'd0,  15'h0000, 7'd0},
    '{DIR_BYTE, sgrd_pkg::REG_WIDTH,  8'h41,                4'd1, 4'd0,  15'h0000, 7'd0},
    // repeated slash restarts the lower band each time
    '{DIR_BYTE, sgrd_pkg::REG_WIDTH,  sgrd_pkg::CHAR_SLASH, 4'd2, 4'd0,  15'h0000, 7'd0},
    '{DIR_BYTE, sgrd_pkg::REG_WIDTH,  8'h42,                4'd1, 4'd0,  15'h0000, 7'd0},
    '{DIR_BYTE, sgrd_pkg::REG_WIDTH,  8'h40,                4'd1, 4'd0,  15'h0000, 7'd0},
    '{DIR_BYTE, sgrd_pkg::REG_WIDTH,  sgrd_pkg::CHAR_SEMI,  4'd1, 4'd0,  15'h0000, 7'd0},
    // seven rows reach into the lower band
    '{DIR_CFG,  sgrd_pkg::REG_HEIGHT, 8'd7,                 4'd1, 4'd0,  15'h0000, 7'd0},
    '{DIR_BYTE, sgrd_pkg::REG_WIDTH,  8'h5E,                4'd2, 4'd0,  15'h0000, 7'd0},
    '{DIR_BYTE, sgrd_pkg::REG_WIDTH,  sgrd_pkg::CHAR_SEMI,  4'd1, 4'd0,  15'h0000, 7'd0}
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [6:0]  cfg_data;

  // Local copy of the decoder state and its registers.
  logic [3:0]  wid_reg;
  logic [3:0]  hgt_reg;
  logic [6:0]  start_reg;
  logic [5:0]  col_store [32];
  logic [4:0]  fill_ptr;
  logic [6:0]  glyphs_left;
  logic        font_ended;

  glyph_row_t  rows_due [$];   // rows predicted but not yet seen

  int          err_count = 0;
  int          n_items = 0;
  bit          tx_idle = 1'b0;
  bit          rx_idle = 1'b0;
  int          rx_hold = 0;

  always #10 clk = ~clk;

  sixel_glyph_row_decoder_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Register clamps.
  function automatic int clamp_cols(input logic [3:0] v);
    if (v < 4'd5) return 5;
    return (v > sgrd_pkg::MAX_WIDTH) ? sgrd_pkg::MAX_WIDTH : int'(v);
  endfunction

  function automatic int clamp_rows(input logic [3:0] v);
    if (v == 4'd0) return 1;
    return (v > sgrd_pkg::MAX_HEIGHT) ? sgrd_pkg::MAX_HEIGHT : int'(v);
  endfunction

  // Glyphs in the font for a given first character code.
  function automatic logic [6:0] font_glyphs(input logic [6:0] s);
    logic [6:0] c;
    c = s;
    if (c == 7'd0) c = 7'd1;
    if (c > sgrd_pkg::GLYPH_LIMIT - 7'd1) c = sgrd_pkg::GLYPH_LIMIT - 7'd1;
    return sgrd_pkg::GLYPH_LIMIT - c;
  endfunction

  // Advance the local decoder by one accepted byte. On a glyph close the
  // rows are queued when keep is set.
  function automatic void decode_byte(input logic [7:0] code, input logic eos,
                                      input bit keep);
    logic       stop;
    logic       close;
    logic       done;
    logic [6:0] gnum;
    logic [6:0] owed;
    logic [14:0] bits;
    int         w;
    int         h;
    int         base;
    if (font_ended || glyphs_left == 7'd0) begin
      font_ended = 1'b1;
      return;
    end
    stop  = eos || code == sgrd_pkg::CHAR_BEL || code > sgrd_pkg::HIGH_LIMIT;
    close = stop || code == sgrd_pkg::CHAR_SEMI;
    if (!close) begin
      if (code == sgrd_pkg::CHAR_SLASH) begin
        fill_ptr = sgrd_pkg::LOWER_BASE;
      end else if (code >= sgrd_pkg::CHAR_QMARK && code <= sgrd_pkg::CHAR_TILDE &&
                   fill_ptr[3:0] < clamp_cols(wid_reg)) begin
        col_store[fill_ptr] = 6'(code - sgrd_pkg::CHAR_QMARK);
        fill_ptr = fill_ptr + 5'd1;
      end
      return;
    end
    w = clamp_cols(wid_reg);
    h = clamp_rows(hgt_reg);
    gnum = font_glyphs(start_reg) - glyphs_left;
    glyphs_left = glyphs_left - 7'd1;
    done = stop || glyphs_left == 7'd0;
    owed = stop ? glyphs_left : 7'd0;
    for (int y = 0; y < h; y++) begin
      base = (y > 5) ? 16 : 0;
      bits = '0;
      for (int x = 0; x < w; x++) bits[x] = col_store[base + x][y % 6];
      if (keep) begin
        rows_due.push_back('{pad: 7'd0,
                             owed: (y == h - 1 && done) ? owed : 7'd0,
                             done: y == h - 1 && done,
                             last: y == h - 1,
                             glyph: gnum, row: 4'(y), bits: bits});
      end
    end
    foreach (col_store[i]) col_store[i] = '0;
    fill_ptr = '0;
    if (done) font_ended = 1'b1;
  endfunction

  function automatic string row_text(input glyph_row_t r);
    return $sformatf("bits=%h row=%0d glyph=%0d last=%b done=%b owed=%0d pad=%h",
                     r.bits, r.row, r.glyph, r.last, r.done, r.owed, r.pad);
  endfunction

  // A byte the decoder must skip (includes 128).
  function automatic logic [7:0] skipped_code();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, sgrd_pkg::HIGH_LIMIT));
    end while (c == sgrd_pkg::CHAR_SLASH || c == sgrd_pkg::CHAR_SEMI ||
               c == sgrd_pkg::CHAR_BEL ||
               (c >= sgrd_pkg::CHAR_QMARK && c <= sgrd_pkg::CHAR_TILDE));
    return c;
  endfunction

  // One request on the slave side, with an optional idle burst in front.
  // Inputs move on the falling edge; acceptance is seen on the rising edge.
  task automatic send_code(input logic [7:0] code, input logic eos, input bit keep);
    int gap;
    if (tx_idle && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk);
      s_tvalid <= 1'b0;
      cfg_we   <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= code;
    s_tlast  <= eos;
    cfg_we   <= 1'b0;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    decode_byte(code, eos, keep);
    if (eos || code == sgrd_pkg::CHAR_SLASH || code == sgrd_pkg::CHAR_SEMI ||
        code == sgrd_pkg::CHAR_BEL || code > sgrd_pkg::HIGH_LIMIT ||
        (code >= sgrd_pkg::CHAR_QMARK && code <= sgrd_pkg::CHAR_TILDE))
      n_items++;
  endtask

  // Stop sending and let every predicted row drain, then keep waiting so fill
  // requests still queued inside are done before a register write.
  task automatic settle_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    cfg_we   <= 1'b0;
    while (rows_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // cfg_we is dropped by whatever drives the next falling edge.
  task automatic write_reg(input sgrd_pkg::cfg_reg_t sel, input logic [6:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    @(posedge clk);
    case (sel)
      sgrd_pkg::REG_WIDTH:  wid_reg = val[3:0];
      sgrd_pkg::REG_HEIGHT: hgt_reg = val[3:0];
      sgrd_pkg::REG_START: begin
        start_reg   = val;
        glyphs_left = font_glyphs(val);
      end
      default: ;
    endcase
  endtask

  // Well-formed glyph body with random content; now and then skipped bytes,
  // overfull bands and an extra slash.
  task automatic send_glyph_body();
    int n;
    n = $urandom_range(0, clamp_cols(wid_reg) + 2);
    repeat (n)
      send_code(8'($urandom_range(sgrd_pkg::CHAR_QMARK, sgrd_pkg::CHAR_TILDE)), 1'b0, 1'b1);
    if ($urandom_range(0, 5) == 0) send_code(skipped_code(), 1'b0, 1'b1);
    if ($urandom_range(0, 3) != 0) begin
      send_code(sgrd_pkg::CHAR_SLASH, 1'b0, 1'b1);
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 4))
          send_code(8'($urandom_range(sgrd_pkg::CHAR_QMARK, sgrd_pkg::CHAR_TILDE)),
                    1'b0, 1'b1);
        send_code(sgrd_pkg::CHAR_SLASH, 1'b0, 1'b1);
      end
      n = $urandom_range(0, clamp_cols(wid_reg) + 2);
      repeat (n)
        send_code(8'($urandom_range(sgrd_pkg::CHAR_QMARK, sgrd_pkg::CHAR_TILDE)),
                  1'b0, 1'b1);
      if ($urandom_range(0, 7) == 0) send_code(skipped_code(), 1'b0, 1'b1);
    end
  endtask

  // Receiver: random stall bursts while rx_idle is set.
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold = rx_hold - 1;
      m_tready <= 1'b0;
    end else if (rx_idle && $urandom_range(0, 7) == 0) begin
      rx_hold = $urandom_range(0, 18);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Row checker: every accepted row is matched against the oldest prediction.
  always @(posedge clk) begin
    glyph_row_t got;
    glyph_row_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{pad: m_tdata[39:33], owed: m_tdata[32:26], done: m_tuser,
              last: m_tlast, glyph: m_tdata[25:19], row: m_tdata[18:15],
              bits: m_tdata[14:0]};
      if (rows_due.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected row: %s", row_text(got));
      end else begin
        want = rows_due.pop_front();
        if (got !== want) begin
          err_count++;
          if (err_count <= 10) begin
            $display("row mismatch");
            $display("  expected %s", row_text(want));
            $display("  actual   %s", row_text(got));
          end
        end
      end
    end
  end

  // Watchdog.
  initial begin
    #40_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    dir_step_t step;
    font_end_t end_mode;
    logic [6:0] val;

    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = sgrd_pkg::REG_WIDTH;
    cfg_data  = '0;

    // local state as after reset
    wid_reg     = sgrd_pkg::RESET_WIDTH;
    hgt_reg     = sgrd_pkg::RESET_HEIGHT;
    start_reg   = sgrd_pkg::RESET_START;
    foreach (col_store[i]) col_store[i] = '0;
    fill_ptr    = '0;
    glyphs_left = font_glyphs(sgrd_pkg::RESET_START);
    font_ended  = 1'b0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // ---- directed table ----
    for (int i = 0; i < DIR_LEN; i++) begin
      step = DIR_TAB[i];
      if (step.kind == DIR_CFG) begin
        settle_idle();
        write_reg(step.sel, step.code[6:0]);
      end else begin
        repeat (step.reps) send_code(step.code, 1'b0, step.pin_rows == 4'd0);
        // typed-in rows for the pinned glyphs
        for (int y = 0; y < step.pin_rows; y++) begin
          rows_due.push_back('{pad: 7'd0, owed: 7'd0, done: 1'b0,
                               last: y == step.pin_rows - 1,
                               glyph: step.pin_glyph, row: 4'(y),
                               bits: step.pin_bits});
        end
      end
    end

    // ---- random phases: settle, rewrite some registers, send glyphs ----
    while (n_items < ITEM_GOAL) begin
      settle_idle();
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 3))
          0:       val = 7'($urandom_range(0, 4));
          1:       val = 7'd15;
          default: val = 7'($urandom_range(5, 15));
        endcase
        // upper data bits are don't-care for the 4-bit registers
        if ($urandom_range(0, 3) == 0) val[6:4] = 3'($urandom_range(0, 7));
        write_reg(sgrd_pkg::REG_WIDTH, val);
      end
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 4))
          0:       val = 7'd0;
          1:       val = 7'($urandom_range(13, 15));
          2:       val = 7'd12;
          default: val = 7'($urandom_range(1, 12));
        endcase
        if ($urandom_range(0, 3) == 0) val[6:4] = 3'($urandom_range(0, 7));
        write_reg(sgrd_pkg::REG_HEIGHT, val);
      end
      // keep enough glyphs in hand so no ';' ends the font early
      if (glyphs_left < 7'd8 || $urandom_range(0, 3) == 0)
        write_reg(sgrd_pkg::REG_START, 7'($urandom_range(0, 70)));

      tx_idle = n_items < QUIET_AFTER && $urandom_range(0, 3) != 0;
      rx_idle = n_items < QUIET_AFTER && $urandom_range(0, 3) != 0;

      for (int g = $urandom_range(1, 5); g > 0; g--) begin
        if (glyphs_left < 7'd2) break;
        send_glyph_body();
        send_code(sgrd_pkg::CHAR_SEMI, 1'b0, 1'b1);
      end
    end

    // ---- end of font: exactly one way per run ----
    settle_idle();
    tx_idle  = 1'b0;
    rx_idle  = 1'b0;
    end_mode = font_end_t'($urandom_range(0, 3));
    if (end_mode == END_LAST_GLYPH)
      write_reg(sgrd_pkg::REG_START, 7'($urandom_range(95, 127)));   // one glyph left
    send_glyph_body();
    case (end_mode)
      END_BEL:  send_code(sgrd_pkg::CHAR_BEL, 1'b0, 1'b1);
      END_HIGH: send_code(8'($urandom_range(sgrd_pkg::HIGH_LIMIT + 1, 255)), 1'b0, 1'b1);
      END_EOS:  send_code(8'($urandom_range(0, 255)), 1'b1, 1'b1);
      default:  send_code(sgrd_pkg::CHAR_SEMI, 1'b0, 1'b1);
    endcase

    // after the end nothing may come out, whatever the byte
    send_code(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    send_code(8'hFF, 1'b0, 1'b1);
    send_code(sgrd_pkg::CHAR_SEMI, 1'b0, 1'b1);
    send_code(sgrd_pkg::CHAR_TILDE, 1'b0, 1'b1);
    @(negedge clk);
    s_tvalid <= 1'b0;

    while (rows_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sixel_glyph_row_decoder_core.f]
+incdir+src
src/sgrd_pkg.sv
src/sgrd_queue.sv
src/sgrd_front.sv
src/sgrd_back.sv
src/sixel_glyph_row_decoder_core.sv
tb/tb_sixel_glyph_row_decoder_core.sv
